>>> hw/rtl/b64enc_pkg.sv
// Shared types, constants and the character table of the base64 stream encoder.
`timescale 1ns / 1ps

package b64enc_pkg;

   // Reset value of the output limit register.
   localparam logic [15:0] LIMIT_RESET = 16'd8193;

   // Characters added to the running count by one group.
   localparam logic [15:0] GROUP_CHARS = 16'd4;

   // Padding character.
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Number of entries in the queue between front and back.
   localparam int QueueDepth = 2;
   localparam int QUEUE_PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QUEUE_CNT_W = $clog2(QueueDepth + 1);

   // Number of bytes in a group, as held in a queue entry.
   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   // Character slots within one group.
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_FOURTH = 2'd3;

   // One input request.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] code_char;
      logic       char_valid;
      logic       end_of_text;
      logic       truncated;
   } rsp_type;

   // One queue entry: a left-aligned group of bytes, or an end marker.
   typedef struct packed {
      logic [23:0] triple;
      logic [1:0]  count;
      logic        last;
      logic        marker;
   } group_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // Standard base64 alphabet.
   function automatic logic [7:0] encode_sextet(input logic [5:0] value);
      logic [7:0] ch;
      begin
         if (value < 6'd26) begin
            ch = 8'h41 + {2'b00, value};
         end else if (value < 6'd52) begin
            ch = 8'h61 + {2'b00, value - 6'd26};
         end else if (value < 6'd62) begin
            ch = 8'h30 + {2'b00, value - 6'd52};
         end else if (value == 6'd62) begin
            ch = 8'h2B;
         end else begin
            ch = 8'h2F;
         end
         return ch;
      end
   endfunction

endpackage

>>> hw/rtl/b64enc_front.sv
// Front part: gathers bytes into groups, applies the output limit and queues groups.
`timescale 1ns / 1ps

module b64enc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  b64enc_pkg::req_type         req_data,
   input  logic                        csr_write_enable,
   input  logic [15:0]                 csr_write_data,
   input  b64enc_pkg::queue_status_type queue_status,
   output logic                        push,
   output b64enc_pkg::group_type       push_data
);

   logic [15:0] limit_ff, limit_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] chars_ff, chars_in;
   logic        stopped_ff, stopped_in;

   logic        accept;
   logic [1:0]  count;
   logic        group_done;
   logic [16:0] chars_next;
   logic        over_limit;
   logic [23:0] aligned;

   // A request is taken whenever the queue has room.
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   assign count      = phase_ff + 2'd1;
   assign group_done = (count == b64enc_pkg::COUNT_THREE) || req_data.last_byte;
   assign chars_next = {1'b0, chars_ff} + {1'b0, b64enc_pkg::GROUP_CHARS};
   assign over_limit = chars_next >= {1'b0, limit_ff};

   // Left-align the completed group in a 24-bit word.
   always_comb begin
      case (count)
         b64enc_pkg::COUNT_ONE:   aligned = {req_data.data_byte, 16'h0000};
         b64enc_pkg::COUNT_TWO:   aligned = {held_ff[7:0], req_data.data_byte, 8'h00};
         default:                 aligned = {held_ff, req_data.data_byte};
      endcase
   end

   // Group and message bookkeeping.
   always_comb begin
      limit_in   = csr_write_enable ? csr_write_data : limit_ff;
      held_in    = held_ff;
      phase_in   = phase_ff;
      chars_in   = chars_ff;
      stopped_in = stopped_ff;
      push       = 1'b0;
      push_data  = '{triple: aligned, count: count, last: req_data.last_byte,
                     marker: 1'b0};
      if (accept) begin
         if (!group_done) begin
            held_in  = {held_ff[7:0], req_data.data_byte};
            phase_in = count;
         end else begin
            held_in  = 16'h0000;
            phase_in = 2'd0;
            if (!stopped_ff) begin
               if (over_limit) begin
                  stopped_in = 1'b1;
               end else begin
                  push     = 1'b1;
                  chars_in = chars_next[15:0];
               end
            end
            if (req_data.last_byte) begin
               // A stopped message ends with one empty marker.
               if (stopped_in) begin
                  push             = 1'b1;
                  push_data.marker = 1'b1;
               end
               chars_in   = 16'h0000;
               stopped_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= b64enc_pkg::LIMIT_RESET;
         held_ff    <= 16'h0000;
         phase_ff   <= 2'd0;
         chars_ff   <= 16'h0000;
         stopped_ff <= 1'b0;
      end else begin
         limit_ff   <= limit_in;
         held_ff    <= held_in;
         phase_ff   <= phase_in;
         chars_ff   <= chars_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

>>> hw/rtl/b64enc_queue.sv
// Short queue of groups between the front and the back.
`timescale 1ns / 1ps

module b64enc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  b64enc_pkg::group_type        push_data,
   input  logic                         pop,
   output b64enc_pkg::group_type        head_data,
   output b64enc_pkg::queue_status_type status
);

   localparam int PtrW = b64enc_pkg::QUEUE_PTR_W;
   localparam int CntW = b64enc_pkg::QUEUE_CNT_W;

   b64enc_pkg::group_type entry_ff [b64enc_pkg::QueueDepth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            do_pop;

   assign status.full      = (fill_ff == CntW'(b64enc_pkg::QueueDepth));
   assign status.not_empty = (fill_ff != '0);
   assign head_data        = entry_ff[rd_ptr_ff];
   assign do_pop           = pop && status.not_empty;

   // Pointer and fill count updates with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(b64enc_pkg::QueueDepth - 1)) ? '0
                                                                       : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(b64enc_pkg::QueueDepth - 1)) ? '0
                                                                       : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/b64enc_back.sv
// Back part: queued groups become registered characters, one per cycle while not stalled.
`timescale 1ns / 1ps

module b64enc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  b64enc_pkg::queue_status_type queue_status,
   input  b64enc_pkg::group_type        head_data,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output b64enc_pkg::rsp_type          rsp_data
);

   logic                rsp_valid_ff, rsp_valid_in;
   b64enc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [1:0]          slot_ff, slot_in;

   logic                out_ready;
   logic [5:0]          sextet;
   logic                pad;
   logic                final_slot;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign final_slot = (slot_ff == b64enc_pkg::SLOT_FOURTH);

   // Pick the sextet of the current slot and decide on padding.
   always_comb begin
      case (slot_ff)
         b64enc_pkg::SLOT_FIRST: begin
            sextet = head_data.triple[23:18];
            pad    = 1'b0;
         end
         b64enc_pkg::SLOT_SECOND: begin
            sextet = head_data.triple[17:12];
            pad    = 1'b0;
         end
         b64enc_pkg::SLOT_THIRD: begin
            sextet = head_data.triple[11:6];
            pad    = (head_data.count == b64enc_pkg::COUNT_ONE);
         end
         default: begin
            sextet = head_data.triple[5:0];
            pad    = (head_data.count != b64enc_pkg::COUNT_THREE);
         end
      endcase
   end

   // Load the output register whenever it is empty or being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      slot_in      = slot_ff;
      pop          = 1'b0;
      if (out_ready) begin
         rsp_valid_in = queue_status.not_empty;
         if (queue_status.not_empty) begin
            if (head_data.marker) begin
               rsp_data_in = '{code_char: 8'h00, char_valid: 1'b0,
                               end_of_text: 1'b1, truncated: 1'b1};
               pop         = 1'b1;
               slot_in     = b64enc_pkg::SLOT_FIRST;
            end else begin
               rsp_data_in = '{code_char: pad ? b64enc_pkg::PAD_CHAR
                                              : b64enc_pkg::encode_sextet(sextet),
                               char_valid: 1'b1,
                               end_of_text: final_slot && head_data.last,
                               truncated: 1'b0};
               pop         = final_slot;
               slot_in     = slot_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         slot_ff      <= b64enc_pkg::SLOT_FIRST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/base64_stream_encoder_top.sv
// Top level of the base64 stream encoder.
`timescale 1ns / 1ps

// Base64 (standard alphabet) encoder over a byte stream. Each request carries one
// byte and a last-byte mark; every third byte, or the last byte of a message,
// completes a group that the front part checks against the output limit and places
// in a two-entry queue. The back part emits four characters per group, padded with
// '=' for a short final group, at one character per cycle into an output register
// while a group is queued and the output is not stalled; bytes that do not complete
// a group are taken while the queue has room. When the running character count plus
// four reaches the output limit, that group and all later ones of the message are
// dropped, and the last byte then gives a single empty result with end_of_text and
// truncated set. Counters clear at the end of each message. The limit register
// resets to 8193 and should be written only while the block is idle.
module base64_stream_encoder_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  b64enc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output b64enc_pkg::rsp_type rsp_data,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data
);

   b64enc_pkg::queue_status_type queue_status;
   b64enc_pkg::group_type        push_data;
   b64enc_pkg::group_type        head_data;
   logic                         push;
   logic                         pop;

   b64enc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .push             (push),
      .push_data        (push_data)
   );

   b64enc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   b64enc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
